// File: hdl/tsb_pkg.sv
// shared types, codes and constants of the text screen buffer
package tsb_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 32;

    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int COLIN_W    = 7;
    localparam int ROWIN_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COLS_REG_W = 8;
    localparam int ROWS_REG_W = 6;

    localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd24;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

    // special bytes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_EOT   = 8'h04;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7f;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic sweep;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            ex_scroll;
        logic            sw_row_last;
        logic            sw_all_last;
    } t_status;

endpackage

// File: hdl/tsb_dp.sv
// datapath: cell memory, cursor, scroll offset, sweep counter and result registers
module tsb_dp #(
    parameter int MAX_COLS = tsb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tsb_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tsb_pkg::t_cmd                    i_cmd,
    output tsb_pkg::t_status                 o_status,
    input  logic [tsb_pkg::OP_W-1:0]         i_opcode,
    input  logic [tsb_pkg::CHAR_W-1:0]       i_char_in,
    input  logic [tsb_pkg::COLIN_W-1:0]      i_col_in,
    input  logic [tsb_pkg::ROWIN_W-1:0]      i_row_in,
    input  logic                             i_cfg_we,
    input  logic [tsb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tsb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [tsb_pkg::CHAR_W-1:0]       o_char_out,
    output logic                             o_read_ok,
    output logic [tsb_pkg::COLIN_W-1:0]      o_cursor_col,
    output logic [tsb_pkg::ROWIN_W-1:0]      o_cursor_row
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int RSW   = ROW_W + 1;
    localparam int AW    = COL_W + ROW_W;
    localparam int DEPTH = 1 << AW;
    localparam int ECW   = $clog2(MAX_COLS + 1);
    localparam int ERW   = $clog2(MAX_ROWS + 1);

    function automatic logic [ECW-1:0] f_eff_cols(input logic [tsb_pkg::COLS_REG_W-1:0] v);
        logic [ECW-1:0] e;
        if (v == '0) begin
            e = ECW'(1);
        end else if (32'(v) > MAX_COLS) begin
            e = ECW'(MAX_COLS);
        end else begin
            e = ECW'(v);
        end
        return e;
    endfunction

    function automatic logic [ERW-1:0] f_eff_rows(input logic [tsb_pkg::ROWS_REG_W-1:0] v);
        logic [ERW-1:0] e;
        if (v == '0) begin
            e = ERW'(1);
        end else if (32'(v) > MAX_ROWS) begin
            e = ERW'(MAX_ROWS);
        end else begin
            e = ERW'(v);
        end
        return e;
    endfunction

    // visible row to physical row in the ring
    function automatic logic [ROW_W-1:0] f_phys(input logic [ROW_W-1:0] b,
                                                 input logic [ROW_W-1:0] r);
        logic [RSW-1:0] s;
        s = {1'b0, b} + {1'b0, r};
        if (s >= RSW'(MAX_ROWS)) begin
            s = s - RSW'(MAX_ROWS);
        end
        return s[ROW_W-1:0];
    endfunction

    logic [tsb_pkg::CHAR_W-1:0] r_mem [DEPTH];

    logic [tsb_pkg::OP_W-1:0]       r_op;
    logic [tsb_pkg::CHAR_W-1:0]     r_ch;
    logic [tsb_pkg::COLIN_W-1:0]    r_col;
    logic [tsb_pkg::ROWIN_W-1:0]    r_row;
    logic [tsb_pkg::COLS_REG_W-1:0] r_cols;
    logic [tsb_pkg::ROWS_REG_W-1:0] r_rows;
    logic [COL_W-1:0]               r_cur_col;
    logic [ROW_W-1:0]               r_cur_line;
    logic [ROW_W-1:0]               r_top;
    logic [AW-1:0]                  r_sw_addr;
    logic [tsb_pkg::CHAR_W-1:0]     r_rd_data;
    logic                           r_rd_ok;
    logic [tsb_pkg::CHAR_W-1:0]     r_char_o;
    logic                           r_ok_o;
    logic [tsb_pkg::COLIN_W-1:0]    r_ccol_o;
    logic [tsb_pkg::ROWIN_W-1:0]    r_crow_o;

    logic [ECW-1:0]             eff_cols, n_eff_cols;
    logic [ERW-1:0]             eff_rows, n_eff_rows;
    logic                       ch_ignore, ch_nl, ch_print;
    logic                       wrap, bottom, is_wr, adv;
    logic [ROW_W-1:0]           cur_prow, top_next, last_vis, scroll_row, rd_prow;
    logic                       rd_hit, mem_we, rd_en, cfg_hit;
    logic [AW-1:0]              waddr, raddr;
    logic [tsb_pkg::CHAR_W-1:0] wdata;

    always_comb begin
        eff_cols = f_eff_cols(r_cols);
        eff_rows = f_eff_rows(r_rows);
        cfg_hit  = i_cfg_we && ((i_cfg_index == tsb_pkg::CFG_COLS) ||
                                (i_cfg_index == tsb_pkg::CFG_ROWS));
        n_eff_cols = (i_cfg_we && i_cfg_index == tsb_pkg::CFG_COLS) ?
                     f_eff_cols(i_cfg_data) : eff_cols;
        n_eff_rows = (i_cfg_we && i_cfg_index == tsb_pkg::CFG_ROWS) ?
                     f_eff_rows(i_cfg_data[tsb_pkg::ROWS_REG_W-1:0]) : eff_rows;

        ch_ignore = (r_ch == tsb_pkg::CH_NUL) || (r_ch == tsb_pkg::CH_EOT) ||
                    (r_ch == tsb_pkg::CH_BS)  || (r_ch == tsb_pkg::CH_DEL);
        ch_nl     = (r_ch == tsb_pkg::CH_CR) || (r_ch == tsb_pkg::CH_LF);
        ch_print  = !ch_ignore && !ch_nl;

        wrap   = (ECW'(r_cur_col) + ECW'(1)) >= eff_cols;
        bottom = (ERW'(r_cur_line) + ERW'(1)) >= eff_rows;
        is_wr  = (r_op == tsb_pkg::OP_WRITE);
        adv    = is_wr && (ch_nl || (ch_print && wrap));

        cur_prow   = f_phys(r_top, r_cur_line);
        top_next   = (r_top == ROW_W'(MAX_ROWS - 1)) ? '0 : r_top + ROW_W'(1);
        last_vis   = ROW_W'(eff_rows - ERW'(1));
        scroll_row = f_phys(top_next, last_vis);
        rd_prow    = f_phys(r_top, ROW_W'(r_row));
        raddr      = {rd_prow, COL_W'(r_col)};
        rd_hit     = (32'(r_col) < 32'(eff_cols)) && (32'(r_row) < 32'(eff_rows));

        mem_we = (i_cmd.exec && is_wr && ch_print) || i_cmd.sweep;
        waddr  = i_cmd.sweep ? r_sw_addr : {cur_prow, r_cur_col};
        wdata  = i_cmd.sweep ? tsb_pkg::CH_BLANK : r_ch;
        rd_en  = i_cmd.exec && (r_op == tsb_pkg::OP_READ);

        o_status.op          = r_op;
        o_status.ex_scroll   = adv && bottom;
        o_status.sw_row_last = (r_sw_addr[COL_W-1:0] == COL_W'(MAX_COLS - 1));
        o_status.sw_all_last = (r_sw_addr == '1);
    end

    // cell memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols     <= tsb_pkg::COLS_RESET;
            r_rows     <= tsb_pkg::ROWS_RESET;
            r_cur_col  <= '0;
            r_cur_line <= '0;
            r_top      <= '0;
            r_sw_addr  <= '0;
        end else if (cfg_hit) begin
            if (i_cfg_index == tsb_pkg::CFG_COLS) begin
                r_cols <= i_cfg_data;
            end else begin
                r_rows <= i_cfg_data[tsb_pkg::ROWS_REG_W-1:0];
            end
            // shrinking pulls the cursor inside the new screen
            if (ECW'(r_cur_col) >= n_eff_cols) begin
                r_cur_col <= COL_W'(n_eff_cols - ECW'(1));
            end
            if (ERW'(r_cur_line) >= n_eff_rows) begin
                r_cur_line <= ROW_W'(n_eff_rows - ERW'(1));
            end
        end else if (i_cmd.exec) begin
            case (r_op)
                tsb_pkg::OP_WRITE: begin
                    if (adv) begin
                        r_cur_col <= '0;
                        if (bottom) begin
                            r_top     <= top_next;
                            r_sw_addr <= {scroll_row, COL_W'(0)};
                        end else begin
                            r_cur_line <= r_cur_line + ROW_W'(1);
                        end
                    end else if (ch_print) begin
                        r_cur_col <= r_cur_col + COL_W'(1);
                    end
                end
                tsb_pkg::OP_CLEAR: begin
                    r_cur_col  <= '0;
                    r_cur_line <= '0;
                    r_top      <= '0;
                    r_sw_addr  <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.sweep) begin
            r_sw_addr <= r_sw_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_opcode;
            r_ch  <= i_char_in;
            r_col <= i_col_in;
            r_row <= i_row_in;
        end
        if (i_cmd.exec) begin
            r_rd_ok <= rd_hit && (r_op == tsb_pkg::OP_READ);
        end
        if (i_cmd.load_out) begin
            r_char_o <= r_rd_ok ? r_rd_data : '0;
            r_ok_o   <= r_rd_ok;
            r_ccol_o <= tsb_pkg::COLIN_W'(r_cur_col);
            r_crow_o <= tsb_pkg::ROWIN_W'(r_cur_line);
        end
    end

    assign o_char_out   = r_char_o;
    assign o_read_ok    = r_ok_o;
    assign o_cursor_col = r_ccol_o;
    assign o_cursor_row = r_crow_o;

endmodule

// File: hdl/tsb_ctrl.sv
// controller: sequences reset fill, execution, blanking sweeps and result handoff
module tsb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  tsb_pkg::t_status i_status,
    output tsb_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_CLEAR  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sw_all_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.op == tsb_pkg::OP_CLEAR) begin
                    n_state = S_CLEAR;
                end else if (i_status.ex_scroll) begin
                    n_state = S_SCROLL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sw_row_last) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sw_all_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/text_screen_buffer_unit.sv
// top level of the text screen buffer: character-cell terminal screen with cursor and scroll
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_stall     i_opcode i_char_in i_col_in i_row_in
//   out       output     o_out_valid / i_out_stall   o_char_out o_read_ok o_cursor_col
//                                                    o_cursor_row
//   cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index i_cfg_data
//
// a write, read or no-op item is accepted, executed, then loaded into the result register
// a scroll blanks the new bottom row, one cell per cycle over the single memory write port while
//   no config write holds the sweep; a clear blanks all 2**(clog2(MAX_COLS)+clog2(MAX_ROWS))
//   cells (4096 at the defaults) in a whole-memory blank sweep
// after reset the same whole-memory blank sweep runs with o_in_stall high; config writes
//   are still taken during it
// a finished result waits in the output register while i_out_stall is high; the next item
//   is accepted meanwhile and holds in its last step until the register frees up
module text_screen_buffer_unit #(
    parameter int MAX_COLS = tsb_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tsb_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [tsb_pkg::OP_W-1:0]       i_opcode,
    input  logic [tsb_pkg::CHAR_W-1:0]     i_char_in,
    input  logic [tsb_pkg::COLIN_W-1:0]    i_col_in,
    input  logic [tsb_pkg::ROWIN_W-1:0]    i_row_in,
    // result output
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tsb_pkg::CHAR_W-1:0]     o_char_out,
    output logic                           o_read_ok,
    output logic [tsb_pkg::COLIN_W-1:0]    o_cursor_col,
    output logic [tsb_pkg::ROWIN_W-1:0]    o_cursor_row,
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tsb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tsb_pkg::t_cmd    cmd;
    tsb_pkg::t_status status;
    logic             cfg_we;

    // register writes land straight in the datapath, always ready
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    tsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // cell ring, cursor and offset live here; rows rotate by offset instead of copying
    tsb_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_opcode     (i_opcode),
        .i_char_in    (i_char_in),
        .i_col_in     (i_col_in),
        .i_row_in     (i_row_in),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_char_out   (o_char_out),
        .o_read_ok    (o_read_ok),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row)
    );

`ifndef SYNTHESIS
    // a result that is not a good read carries a zero byte
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_read_ok) |-> (o_char_out == 8'h00))
        else $error("non-read result with nonzero byte");

    // after taking an item the controller is busy on it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // a new result only appears out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work");
`endif

endmodule
